>>> hdl/tse_pkg.sv
// tse_pkg: shared constants and types for the trajectory speed estimator.
// No dependencies; used by tse_div and trajectory_speed_estimator_unit in hdl/.
`timescale 1ns / 1ps
`default_nettype none
package tse_pkg;
   localparam int unsigned MaxSegments = 65535;
   localparam int unsigned CountW = 16;
   localparam int unsigned SumW = 48;

   // Request to the restoring divider.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [47:0] divisor;
   } div_req_type;

   // Status back from the divider.
   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

>>> hdl/tse_div.sv
// tse_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on tse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tse_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tse_pkg::div_req_type req,
   output tse_pkg::div_rsp_type    rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [48:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;
   logic [49:0] diff;

   always_comb begin
      trial = {rem_ff[47:0], quo_ff[63]};
      diff = {1'b0, trial} - {2'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         den_in = req.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[49]) begin
            rem_in = diff[48:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

>>> hdl/tse_sqrt.sv
// tse_sqrt: digit-by-digit integer square root, one result bit per cycle.
// No dependencies; does not use tse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tse_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [33:0] sub;

   always_comb begin
      trial = {rem_ff[31:0], rad_ff[63:62]};
      sub = {root_ff, 2'b01};
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (trial >= sub) begin
            rem_in = trial - sub;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

>>> hdl/tse_mul.sv
// tse_mul: bit-serial squarer/accumulator: acc += a*a, one multiplier bit per cycle.
// Used twice per segment to form vx^2 + vy^2; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tse_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        clear_acc,
   input  wire logic [31:0] operand,
   output logic             done,
   output logic [63:0]      acc
);
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         if (clear_acc) acc_in = '0;
         mcand_in = {32'b0, operand};
         mplier_in = operand;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in = {mcand_ff[62:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[31:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign acc = acc_ff;
endmodule
`default_nettype wire

>>> hdl/trajectory_speed_estimator_unit.sv
// trajectory_speed_estimator_unit: top level, sequencer around serial divide,
// square and square-root units. Depends on tse_pkg, tse_div, tse_mul, tse_sqrt.
//
//  channel | direction | payload
//  req_    | in        | tdata = sample_time, pos_x, pos_y; tuser = track_start
//  rsp_    | out       | tdata = vel_x, vel_y, speed, mid_time, speed_min,
//          |           |         speed_max, speed_avg
//
// For a segment beat the sequencer runs two divides (vx, vy), two squarings, a
// root and an average divide on the shared divider, then loads the output
// register that raises rsp_tvalid. A track-start sample, or the first sample
// after reset, is absorbed without a result. Reset clears history and stats.
// The result is held in the output register until taken; the next beat is
// accepted only once the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module trajectory_speed_estimator_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // sample_time[31:0], pos_x[63:32], pos_y[95:64]
   input  wire logic [95:0]  req_tdata,
   // track_start[0]
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // vel_x, vel_y, speed, mid_time, speed_min, speed_max, speed_avg (32 bits each)
   output logic [223:0]      rsp_tdata
);
   typedef enum logic [3:0] {
      S_IDLE, S_DIVX, S_WX, S_DIVY, S_WY, S_SQX, S_WSQX, S_SQY, S_WSQY, S_ROOT,
      S_STATS, S_AVG, S_WAVG, S_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] prev_t_ff, prev_x_ff, prev_y_ff;
   logic        have_prev_ff;
   logic [31:0] min_ff, max_ff;
   logic [tse_pkg::SumW-1:0]   sum_ff;
   logic [tse_pkg::CountW-1:0] cnt_ff;
   logic [31:0] vx_ff, vy_ff, spd_ff, mid_ff;
   logic [32:0] dt_ff, dx_ff, dy_ff;
   logic        out_valid_ff;
   logic [223:0] out_ff;

   tse_pkg::div_req_type div_req;
   tse_pkg::div_rsp_type div_rsp;
   logic        mul_start, mul_clear, mul_done, sq_start, sq_done;
   logic [31:0] mul_op, root;
   logic [63:0] mul_acc;

   tse_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   tse_mul u_mul (.clock(clock), .reset(reset), .start(mul_start), .clear_acc(mul_clear),
                  .operand(mul_op), .done(mul_done), .acc(mul_acc));
   tse_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start), .radicand(mul_acc),
                    .done(sq_done), .root(root));

   logic [32:0] adt, anum;
   logic        neg;
   logic [31:0] vsat;
   logic [32:0] mag_x, mag_y;
   logic [48:0] sum_next;
   logic [31:0] smin, smax;

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;

   always_comb begin
      adt = dt_ff[32] ? (~dt_ff + 33'd1) : dt_ff;
      anum = (state_ff == S_WX || state_ff == S_DIVX) ? dx_ff : dy_ff;
      neg = anum[32] ^ dt_ff[32];
      if (anum[32]) anum = ~anum + 33'd1;
      // saturate divider quotient into signed 32
      if (neg) begin
         if (div_rsp.quotient > 64'h8000_0000) vsat = 32'h8000_0000;
         else vsat = 32'(~div_rsp.quotient[31:0] + 32'd1);
      end else begin
         if (div_rsp.quotient > 64'h7FFF_FFFF) vsat = 32'h7FFF_FFFF;
         else vsat = div_rsp.quotient[31:0];
      end
      if (dt_ff == '0) vsat = '0;
      mag_x = vx_ff[31] ? (33'd0 - {1'b1, vx_ff}) : {1'b0, vx_ff};
      mag_y = vy_ff[31] ? (33'd0 - {1'b1, vy_ff}) : {1'b0, vy_ff};

      div_req.start = (state_ff == S_DIVX) || (state_ff == S_DIVY) || (state_ff == S_AVG);
      if (state_ff == S_AVG) begin
         div_req.dividend = {16'b0, sum_ff};
         div_req.divisor = {32'b0, cnt_ff};
      end else begin
         div_req.dividend = {15'b0, anum, 16'b0};
         div_req.divisor = {15'b0, adt};
      end
      mul_start = (state_ff == S_SQX) || (state_ff == S_SQY);
      mul_clear = (state_ff == S_SQX);
      mul_op = (state_ff == S_SQX) ? mag_x[31:0] : mag_y[31:0];
      sq_start = (state_ff == S_ROOT);

      // stats take the new root in the cycle it arrives
      sum_next = {1'b0, sum_ff} + {17'b0, root};
      smin = (root < min_ff) ? root : min_ff;
      smax = (root > max_ff) ? root : max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         have_prev_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         min_ff <= '1;
         max_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
         prev_t_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  prev_t_ff <= req_tdata[31:0];
                  prev_x_ff <= req_tdata[63:32];
                  prev_y_ff <= req_tdata[95:64];
                  have_prev_ff <= 1'b1;
                  if (req_tuser || !have_prev_ff) begin
                     min_ff <= '1;
                     max_ff <= '0;
                     sum_ff <= '0;
                     cnt_ff <= '0;
                  end else begin
                     mid_ff <= 32'(({1'b0, req_tdata[31:0]} + {1'b0, prev_t_ff}) >> 1);
                     dt_ff <= {1'b0, req_tdata[31:0]} - {1'b0, prev_t_ff};
                     dx_ff <= {req_tdata[63], req_tdata[63:32]} - {prev_x_ff[31], prev_x_ff};
                     dy_ff <= {req_tdata[95], req_tdata[95:64]} - {prev_y_ff[31], prev_y_ff};
                     state_ff <= S_DIVX;
                  end
               end
            end
            S_DIVX: state_ff <= S_WX;
            S_WX: if (div_rsp.done) begin
               vx_ff <= vsat;
               state_ff <= S_DIVY;
            end
            S_DIVY: state_ff <= S_WY;
            S_WY: if (div_rsp.done) begin
               vy_ff <= vsat;
               state_ff <= S_SQX;
            end
            S_SQX: state_ff <= S_WSQX;
            S_WSQX: if (mul_done) state_ff <= S_SQY;
            S_SQY: state_ff <= S_WSQY;
            S_WSQY: if (mul_done) state_ff <= S_ROOT;
            S_ROOT: state_ff <= S_STATS;
            S_STATS: if (sq_done) begin
               spd_ff <= root;
               min_ff <= smin;
               max_ff <= smax;
               if (32'(cnt_ff) < tse_pkg::MaxSegments) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  sum_ff <= sum_next[48] ? '1 : sum_next[47:0];
               end
               state_ff <= S_AVG;
            end
            S_AVG: state_ff <= S_WAVG;
            S_WAVG: if (div_rsp.done) state_ff <= S_OUT;
            S_OUT: begin
               out_ff <= {(div_rsp.quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                          : div_rsp.quotient[31:0], max_ff, min_ff, mid_ff, spd_ff,
                          vy_ff, vx_ff};
               out_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> dv/trajectory_speed_estimator_unit_tb.sv
// Testbench for trajectory_speed_estimator_unit: directed table then random samples,
// every result checked against an in-bench velocity/speed predictor or a typed-in result.
// Depends on tse_pkg and the hdl/ sources of the unit.
`timescale 1ns / 1ps
module trajectory_speed_estimator_unit_tb;

   typedef struct packed {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic        start;
   } sample_type;

   typedef struct packed {
      logic [31:0] avg;
      logic [31:0] smax;
      logic [31:0] smin;
      logic [31:0] mid;
      logic [31:0] spd;
      logic [31:0] vy;
      logic [31:0] vx;
   } segment_type;

   // directed row: sample, whether a known result is typed in, and that result
   typedef struct {
      sample_type  s;
      bit          fixed;
      segment_type res;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // sample_time, pos_x, pos_y from bit 0 up
   logic [95:0]  req_tdata = '0;
   // track_start
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // vel_x, vel_y, speed, mid_time, speed_min, speed_max, speed_avg from bit 0 up
   logic [223:0] rsp_tdata;

   trajectory_speed_estimator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [31:0]        last_t;
   logic signed [31:0] last_x, last_y;
   bit                 have_last;
   logic [31:0]        run_min, run_max;
   logic [47:0]        run_sum;
   logic [15:0]        run_cnt;

   segment_type segment_q[$];
   int       errors = 0;
   int       n_checked = 0;
   int       n_tracks = 0;
   bit       quiet_rx = 1'b0;
   bit       quiet_tx = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      errors++;
      $display("mismatch %s: got %h expected %h (beat %0d)", what, got, exp, n_checked);
   endtask

   task automatic enqueue(input segment_type seg);
      segment_q = {segment_q, seg};
   endtask

   function automatic logic [31:0] q16_rate(input logic signed [33:0] num,
                                           input logic signed [33:0] den);
      logic [63:0] n, d, q;
      bit neg;
      if (den == 0) return 32'd0;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? 64'(-num) : 64'(num);
      n = n << 16;
      d = (den < 0) ? 64'(-den) : 64'(den);
      q = n / d;
      if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void clear_track();
      run_min = '1;
      run_max = '0;
      run_sum = '0;
      run_cnt = '0;
   endfunction

   // returns 1 and fills seg when the sample closes a segment
   function automatic bit predict_segment(input sample_type s, output segment_type seg);
      logic signed [33:0] dt;
      logic signed [63:0] vx, vy;
      logic [63:0] sq, sp, sum;
      if (s.start || !have_last) begin
         clear_track();
         last_t = s.t; last_x = s.x; last_y = s.y;
         have_last = 1'b1;
         seg = '0;
         return 1'b0;
      end
      dt = $signed({2'b00, s.t}) - $signed({2'b00, last_t});
      seg.vx = q16_rate($signed(34'(signed'(s.x))) - 34'(last_x), dt);
      seg.vy = q16_rate($signed(34'(signed'(s.y))) - 34'(last_y), dt);
      vx = 64'(signed'(seg.vx));
      vy = 64'(signed'(seg.vy));
      sq = 64'(vx * vx) + 64'(vy * vy);
      sp = root64(sq);
      if (sp > 64'hFFFF_FFFF) sp = 64'hFFFF_FFFF;
      seg.spd = sp[31:0];
      seg.mid = 32'(({32'd0, last_t} + {32'd0, s.t}) >> 1);
      if (seg.spd < run_min) run_min = seg.spd;
      if (seg.spd > run_max) run_max = seg.spd;
      if (run_cnt < 16'(tse_pkg::MaxSegments)) begin
         run_cnt++;
         sum = {16'd0, run_sum} + sp;
         run_sum = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
      end
      sum = (run_cnt != 0) ? {16'd0, run_sum} / run_cnt : 64'd0;
      seg.avg = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      seg.smin = run_min;
      seg.smax = run_max;
      last_t = s.t; last_x = s.x; last_y = s.y;
      return 1'b1;
   endfunction

   // tvalid stays high into the next beat unless an idle cycle is drawn
   task automatic send_sample(input sample_type s);
      while (!quiet_tx && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.y, s.x, s.t};
      req_tuser  <= s.start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (s.start) n_tracks++;
   endtask

   // receiver: random stall, compare every beat taken
   always @(posedge clock) begin
      segment_type got, exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            n_checked++;
            if (segment_q.size() == 0) begin
               report("unexpected beat", got.vx, 32'h0);
            end else begin
               exp = segment_q.pop_front();
               if (got.vx !== exp.vx) report("vel_x", got.vx, exp.vx);
               if (got.vy !== exp.vy) report("vel_y", got.vy, exp.vy);
               if (got.spd !== exp.spd) report("speed", got.spd, exp.spd);
               if (got.mid !== exp.mid) report("mid_time", got.mid, exp.mid);
               if (got.smin !== exp.smin) report("speed_min", got.smin, exp.smin);
               if (got.smax !== exp.smax) report("speed_max", got.smax, exp.smax);
               if (got.avg !== exp.avg) report("speed_avg", got.avg, exp.avg);
            end
         end
         rsp_tready <= quiet_rx || ($urandom_range(99) >= 32);
      end
   end

   function automatic sample_type mk(input logic [31:0] t, input logic [31:0] x,
                                     input logic [31:0] y, input bit st);
      sample_type s;
      s.t = t; s.x = x; s.y = y; s.start = st;
      return s;
   endfunction

   function automatic segment_type mkres(input logic [31:0] vx, input logic [31:0] vy,
                                         input logic [31:0] sp, input logic [31:0] mid,
                                         input logic [31:0] mn, input logic [31:0] mx,
                                         input logic [31:0] av);
      segment_type r;
      r.vx = vx; r.vy = vy; r.spd = sp; r.mid = mid; r.smin = mn; r.smax = mx; r.avg = av;
      return r;
   endfunction

   function automatic logic [31:0] rnd_pos(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'(signed'($urandom_range(2000)) - 1000) << 12;
         default: return 32'(signed'($urandom_range(200000)) - 100000);
      endcase
   endfunction

   initial begin
      row_type     plan[14];
      sample_type  s;
      segment_type seg;
      logic [31:0] t;
      int mode, len;

      // first sample after reset opens a track even without the flag
      plan[0] = '{mk(32'h0001_0000, 32'h0, 32'h0, 1'b0), 1'b0, '0};
      // one metre in x over one second
      plan[1] = '{mk(32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0), 1'b1,
                  mkres(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_8000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000)};
      // equal times give zero velocity, and the zero speed enters the stats
      plan[2] = '{mk(32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0), 1'b1,
                  mkres(32'h0, 32'h0, 32'h0, 32'h0002_0000, 32'h0, 32'h0001_0000,
                        32'h0000_8000)};
      // time running backwards: opposite sign
      plan[3] = '{mk(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0), 1'b0, '0};
      // extreme positions over the smallest time step (saturated velocities) and the largest
      plan[4] = '{mk(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1), 1'b0, '0};
      plan[5] = '{mk(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0), 1'b0, '0};
      plan[6] = '{mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0), 1'b0, '0};
      plan[7] = '{mk(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0), 1'b0, '0};
      plan[8] = '{mk(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0), 1'b0, '0};
      // a flag on a fresh track clears stats
      plan[9] = '{mk(32'h8000_0000, 32'h0, 32'h0, 1'b1), 1'b0, '0};
      plan[10] = '{mk(32'h8000_0000, 32'h0, 32'h0, 1'b1), 1'b0, '0};
      plan[11] = '{mk(32'h8002_0000, 32'hFFFE_0000, 32'h0002_0000, 1'b0), 1'b0, '0};
      plan[12] = '{mk(32'h8003_0000, 32'hFFFD_0000, 32'h0005_0000, 1'b0), 1'b0, '0};
      plan[13] = '{mk(32'h8003_0001, 32'hFFFD_0000, 32'h0005_0000, 1'b0), 1'b0, '0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      have_last = 1'b0;
      last_t = '0; last_x = '0; last_y = '0;
      clear_track();

      foreach (plan[i]) begin
         if (predict_segment(plan[i].s, seg))
            enqueue(plan[i].fixed ? plan[i].res : seg);
         send_sample(plan[i].s);
      end

      // random tracks: mostly plausible motion, some full-range noise
      len = 0;
      for (int n = 0; n < 1250; n++) begin
         quiet_tx = (n >= 500 && n < 650);
         quiet_rx = (n >= 550 && n < 700);
         if (len == 0) begin
            len = $urandom_range(60, 2);
            mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
            t = $urandom;
            s = mk(t, rnd_pos(mode), rnd_pos(mode), 1'b1);
         end else begin
            case ($urandom_range(15))
               0: t = $urandom;
               1: ;
               2: t = t - $urandom_range(32'h0002_0000);
               default: t = t + $urandom_range(32'h0004_0000, 1);
            endcase
            s = mk(t, s.x + (rnd_pos(mode) >>> ($urandom_range(1) ? 0 : 4)),
                   s.y + rnd_pos(mode), $urandom_range(40) == 0);
         end
         len--;
         if (predict_segment(s, seg)) enqueue(seg);
         send_sample(s);
      end
      req_tvalid <= 1'b0;
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;

      while (segment_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("covered %0d result beats over %0d flagged tracks", n_checked, n_tracks);
      if (errors == 0 && segment_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", segment_q.size());
      $display("FAILED: results differ");
      $finish;
   end
endmodule
